[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AST_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define AST_PROP_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define AST_PROP(lbl, prop)
`define AST_PROP_MSG(lbl, prop, msg)
`endif

`endif

[hw/rtl/tapf_pkg.sv]
// ----------------------------------------------------------------------------
// tapf_pkg
// Shared types and constants of the three-axis PI drive controller.
// ----------------------------------------------------------------------------
package tapf_pkg;

  localparam int unsigned NumAxes   = 3;
  localparam int unsigned GainW     = 16;
  localparam int unsigned PwmW      = 15;
  localparam int unsigned IntegW    = 16;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned AccW      = 17;
  localparam int unsigned PosW      = 32;
  localparam int unsigned DriveW    = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 2 * NumAxes * SampleW;
  localparam int unsigned OutDataW  = NumAxes * (DriveW + PosW);

  localparam logic [GainW-1:0]  KpReset    = 16'd14080;
  localparam logic [GainW-1:0]  KiDtReset  = 16'd461;
  localparam logic [GainW-1:0]  KffReset   = 16'd3072;
  localparam logic [PwmW-1:0]   PwmReset   = 15'd7200;
  localparam logic [IntegW-1:0] IntegReset = 16'd1800;

  typedef enum logic [1:0] {
    OP_UPDATE  = 2'd0,
    OP_CLR_POS = 2'd1,
    OP_CLR_ALL = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP    = 3'd0,
    REG_KI_DT = 3'd1,
    REG_KFF   = 3'd2,
    REG_PWM   = 3'd3,
    REG_INTEG = 3'd4
  } reg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_SUM  = 7'b0000100,
    ST_ACC  = 7'b0001000,
    ST_MUL2 = 7'b0010000,
    ST_DRV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [GainW-1:0]  kp;
    logic [GainW-1:0]  ki_dt;
    logic [GainW-1:0]  kff;
    logic [PwmW-1:0]   pwm_limit;
    logic [IntegW-1:0] integ_limit;
  } gains_t;

  typedef struct packed {
    logic load;
    logic add_pos;
    logic clr_pos;
    logic clr_acc;
    logic mul1;
    logic sum;
    logic acc_upd;
    logic mul2;
    logic drv;
  } lane_ctrl_t;

endpackage

[hw/rtl/tapf_lane.sv]
// ----------------------------------------------------------------------------
// tapf_lane
// One axis: position total, error accumulator with conditional integration,
// and the PI plus feedforward datapath stepped by the sequencer.
// ----------------------------------------------------------------------------
module tapf_lane
  import tapf_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lane_ctrl_t                ctrl_i,
  input  gains_t                    gains_i,
  input  logic signed [SampleW-1:0] target_i,
  input  logic signed [SampleW-1:0] delta_i,
  output logic signed [DriveW-1:0]  drive_o,
  output logic [PosW-1:0]           position_o
);

  localparam int unsigned ProdW = 34;
  localparam int unsigned SumW  = 36;

  logic signed [SampleW-1:0] tgt_q, dlt_q;
  logic [PosW-1:0]           pos_q, pos_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [AccW-1:0]    e_q, e_d;
  logic signed [ProdW-1:0]   pe_q, pt_q, pa_q, pe_d, pt_d, pa_d;
  logic signed [SumW-1:0]    base_q;
  logic signed [DriveW-1:0]  drive_q;

  logic signed [AccW-1:0]    kp_s, ki_s, kff_s;
  logic signed [SumW-1:0]    u_w, lim_q_w, quo_w, plim_w, dsat_w;
  logic signed [AccW:0]      acc_sum_w, ilim_w;
  logic                      sat_w, e_pos_w, e_neg_w;

  assign kp_s  = $signed({1'b0, gains_i.kp});
  assign ki_s  = $signed({1'b0, gains_i.ki_dt});
  assign kff_s = $signed({1'b0, gains_i.kff});

  assign e_d  = AccW'(tgt_q) - AccW'(dlt_q);
  assign pe_d = ProdW'(kp_s) * ProdW'(e_d);
  assign pt_d = ProdW'(kff_s) * ProdW'(tgt_q);
  assign pa_d = ProdW'(ki_s) * ProdW'(acc_q);

  // u from the held kp/kff part and the current integral product
  assign u_w     = base_q + SumW'(pa_q);
  assign lim_q_w = $signed({13'b0, gains_i.pwm_limit, 8'b0});
  assign e_pos_w = !e_q[AccW-1] && (e_q != '0);
  assign e_neg_w = e_q[AccW-1];
  assign sat_w   = ((u_w >= lim_q_w) && e_pos_w) || ((u_w <= -lim_q_w) && e_neg_w);

  assign acc_sum_w = sat_w ? (AccW+1)'(acc_q) : (AccW+1)'(acc_q) + (AccW+1)'(e_q);
  assign ilim_w    = $signed({2'b0, gains_i.integ_limit});

  always_comb begin
    if (acc_sum_w > ilim_w) begin
      acc_d = AccW'(ilim_w);
    end else if (acc_sum_w < -ilim_w) begin
      acc_d = AccW'(-ilim_w);
    end else begin
      acc_d = AccW'(acc_sum_w);
    end
  end

  // truncate toward zero, then clamp to the drive bound
  assign quo_w  = u_w[SumW-1] ? ((u_w + SumW'(255)) >>> 8) : (u_w >>> 8);
  assign plim_w = $signed({21'b0, gains_i.pwm_limit});

  always_comb begin
    if (quo_w > plim_w) begin
      dsat_w = plim_w;
    end else if (quo_w < -plim_w) begin
      dsat_w = -plim_w;
    end else begin
      dsat_w = quo_w;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.clr_pos) begin
      pos_d = '0;
    end else if (ctrl_i.add_pos) begin
      pos_d = pos_q + PosW'(delta_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
    end else begin
      pos_q <= pos_d;
      if (ctrl_i.clr_acc) begin
        acc_q <= '0;
      end else if (ctrl_i.acc_upd) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      tgt_q <= target_i;
      dlt_q <= delta_i;
    end
    if (ctrl_i.mul1) begin
      e_q  <= e_d;
      pe_q <= pe_d;
      pt_q <= pt_d;
      pa_q <= pa_d;
    end else if (ctrl_i.mul2) begin
      pa_q <= pa_d;
    end
    if (ctrl_i.sum) begin
      base_q <= SumW'(pe_q) + SumW'(pt_q);
    end
    if (ctrl_i.drv) begin
      drive_q <= DriveW'(dsat_w);
    end
  end

  assign drive_o    = drive_q;
  assign position_o = pos_q;

endmodule

[hw/rtl/tapf_merge.sv]
// ----------------------------------------------------------------------------
// tapf_merge
// Gathers the lane results into one output transfer and holds it until the
// downstream side takes it.
// ----------------------------------------------------------------------------
module tapf_merge
  import tapf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic                     zero_i,
  input  logic signed [DriveW-1:0] drive_i [NumAxes],
  input  logic [PosW-1:0]          position_i [NumAxes],
  output logic                     can_load_o,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata
);

  logic                valid_q;
  logic [OutDataW-1:0] data_q, data_d;

  always_comb begin
    data_d = '0;
    for (int k = 0; k < NumAxes; k++) begin
      data_d[k*DriveW +: DriveW] = zero_i ? '0 : drive_i[k];
      data_d[NumAxes*DriveW + k*PosW +: PosW] = position_i[k];
    end
  end

  assign can_load_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

[hw/rtl/three_axis_pi_feedforward_controller.sv]
// ----------------------------------------------------------------------------
// three_axis_pi_feedforward_controller
// Three-axis PI speed controller with target feedforward, anti-windup and
// wrapping position totals.
// ----------------------------------------------------------------------------
// One input transfer gives one output transfer. A control update with a
// nonzero target steps from acceptance to the next ready through multiply,
// sum, integrator update, second integral multiply, drive rounding and output
// load, set by the shared sequencer that steps all three axis lanes together.
// Clear operations, unused codes and all-zero targets go straight from
// acceptance to the output load. A new item is taken while the previous
// result still waits in the output register; an item only stalls in its last step if that register is still full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_axis_pi_feedforward_controller
  import tapf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // target_a, target_b, target_c, delta_a, delta_b, delta_c
  input  logic [InDataW-1:0]    s_axis_tdata,
  // operation
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // drive_a, drive_b, drive_c, position_a, position_b, position_c
  output logic [OutDataW-1:0]   m_axis_tdata
);

  gains_t     gains_q;
  state_e     state_q, state_d;
  logic       zero_q, zero_d;
  lane_ctrl_t ctrl;
  logic       accept, all_zero, can_load, out_load;

  logic signed [SampleW-1:0] tgt_w [NumAxes];
  logic signed [SampleW-1:0] dlt_w [NumAxes];
  logic signed [DriveW-1:0]  drive_w [NumAxes];
  logic [PosW-1:0]           pos_w [NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.kp          <= KpReset;
      gains_q.ki_dt       <= KiDtReset;
      gains_q.kff         <= KffReset;
      gains_q.pwm_limit   <= PwmReset;
      gains_q.integ_limit <= IntegReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KP:    gains_q.kp          <= cfg_data_i;
        REG_KI_DT: gains_q.ki_dt       <= cfg_data_i;
        REG_KFF:   gains_q.kff         <= cfg_data_i;
        REG_PWM:   gains_q.pwm_limit   <= cfg_data_i[PwmW-1:0];
        REG_INTEG: gains_q.integ_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      tgt_w[k] = s_axis_tdata[k*SampleW +: SampleW];
      dlt_w[k] = s_axis_tdata[(NumAxes+k)*SampleW +: SampleW];
    end
  end

  assign all_zero      = (tgt_w[0] == '0) && (tgt_w[1] == '0) && (tgt_w[2] == '0);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_OUT) && can_load;

  always_comb begin
    ctrl         = '0;
    ctrl.load    = accept;
    ctrl.add_pos = accept && (s_axis_tuser == OP_UPDATE);
    ctrl.clr_pos = accept && ((s_axis_tuser == OP_CLR_POS) || (s_axis_tuser == OP_CLR_ALL));
    ctrl.clr_acc = accept && ((s_axis_tuser == OP_CLR_ALL) ||
                              ((s_axis_tuser == OP_UPDATE) && all_zero));
    ctrl.mul1    = (state_q == ST_MUL);
    ctrl.sum     = (state_q == ST_SUM);
    ctrl.acc_upd = (state_q == ST_ACC);
    ctrl.mul2    = (state_q == ST_MUL2);
    ctrl.drv     = (state_q == ST_DRV);
  end

  always_comb begin
    state_d = state_q;
    zero_d  = zero_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((s_axis_tuser == OP_UPDATE) && !all_zero) begin
            zero_d  = 1'b0;
            state_d = ST_MUL;
          end else begin
            zero_d  = 1'b1;
            state_d = ST_OUT;
          end
        end
      end
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_MUL2;
      ST_MUL2: state_d = ST_DRV;
      ST_DRV:  state_d = ST_OUT;
      ST_OUT: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      zero_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      zero_q  <= zero_d;
    end
  end

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    tapf_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .gains_i    (gains_q),
      .target_i   (tgt_w[g]),
      .delta_i    (dlt_w[g]),
      .drive_o    (drive_w[g]),
      .position_o (pos_w[g])
    );
  end

  tapf_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .zero_i        (zero_q),
    .drive_i       (drive_w),
    .position_i    (pos_w),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `AST_PROP(a_accept_busy, accept |=> (state_q != ST_IDLE))
  `AST_PROP(a_load_valid, out_load |=> m_axis_tvalid)
  `AST_PROP_MSG(a_clear_zero, (out_load && zero_q) |=> (m_axis_tdata[NumAxes*DriveW-1:0] == '0), "clear transfer carries nonzero drive")

endmodule
